FILE: src/lcb_pkg.sv
// Package for the lane centerline builder: payload structs, phase and
// sequencer state encodings, default widths. No dependencies.
package lcb_pkg;

    localparam int CoordBits = 32;
    localparam int ArcBits   = 40;

    typedef struct packed {
        logic signed [CoordBits-1:0] left_x;
        logic signed [CoordBits-1:0] left_y;
        logic signed [CoordBits-1:0] left_z;
        logic signed [CoordBits-1:0] right_x;
        logic signed [CoordBits-1:0] right_y;
        logic signed [CoordBits-1:0] right_z;
        logic                        final_pair;
    } in_item_t;

    typedef struct packed {
        logic signed [CoordBits-1:0] center_x;
        logic signed [CoordBits-1:0] center_y;
        logic signed [CoordBits-1:0] center_z;
        logic        [CoordBits-1:0] left_width;
        logic        [CoordBits-1:0] right_width;
        logic        [ArcBits-1:0]   arc_length;
        logic                        end_of_line;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ONE  = 2'd1,
        PH_HELD = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LW,
        ST_RW,
        ST_DOT,
        ST_SEG,
        ST_DECIDE,
        ST_EMIT_HELD,
        ST_UPDATE,
        ST_EMIT_FIN,
        ST_WAIT
    } seq_state_t;

endpackage

FILE: src/lcb_norm.sv
// Iterative 3D vector length: floor(sqrt(dx^2+dy^2+dz^2)).
// Sum of squares through one shared multiplier, then one result bit a cycle.
// Depends on nothing outside this file.
module lcb_norm #(
    parameter int DW = 33
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW-1:0] dx,
    input  logic signed [DW-1:0] dy,
    input  logic signed [DW-1:0] dz,
    output logic                 done,
    output logic [DW-1:0]        root
);
    localparam int SW = 2 * DW + 2;
    localparam int CW = $clog2(DW + 3);

    logic [DW-1:0] mx_reg, my_reg, mz_reg;
    logic [SW-1:0] sum_reg;
    logic [DW-1:0] root_reg;
    logic [SW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0]    sq_reg;
    logic          busy_reg, sqr_reg, done_reg;
    logic [DW-1:0] mul_a;
    logic [2*DW-1:0] prod;

    logic [SW-1:0] rem_sh, trial;
    logic [CW-1:0] bit_pos;

    function automatic logic [DW-1:0] absv(input logic signed [DW-1:0] v);
        absv = v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // One shared multiplier squares the three magnitudes in turn
    always_comb begin
        unique case (sq_reg)
            2'd0:    mul_a = mx_reg;
            2'd1:    mul_a = my_reg;
            default: mul_a = mz_reg;
        endcase
        prod = (2*DW)'(mul_a) * (2*DW)'(mul_a);
    end

    // Restoring square root step: bring down two bits, try 4r+1
    always_comb begin
        bit_pos = cnt_reg - CW'(1);
        rem_sh  = (rem_reg << 2) | SW'((sum_reg >> (2 * bit_pos)) & SW'(3));
        trial   = (SW'(root_reg) << 2) | SW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sqr_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                sqr_reg  <= 1'b0;
                sq_reg   <= 2'd0;
                mx_reg   <= absv(dx);
                my_reg   <= absv(dy);
                mz_reg   <= absv(dz);
                sum_reg  <= '0;
            end else if (busy_reg && !sqr_reg) begin
                sum_reg <= sum_reg + SW'(prod);
                if (sq_reg == 2'd2) begin
                    sqr_reg  <= 1'b1;
                    cnt_reg  <= CW'(DW + 1);
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                sq_reg <= sq_reg + 2'd1;
            end else if (busy_reg) begin
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= (root_reg << 1) | DW'(1);
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= root_reg << 1;
                end
                cnt_reg <= bit_pos;
                if (bit_pos == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

FILE: src/lane_centerline_builder.sv
// Lane centerline builder top level: sequencer, held/anchor state, output
// register. Depends on lcb_pkg and lcb_norm.
//
// Usage: boundary pairs enter on s_ (valid/ready); centerline points leave
// on m_ (valid/ready). Each pair makes 0, 1 or 2 transactions out.
// The block takes one pair at a time and is not ready while it works.
// The shared norm unit runs up to three times per pair (left width, right
// width, segment length); the first pair of a polyline needs only the two
// widths. A point appears on m_ in the cycle after its emit step. The norm
// unit's square root, one bit a cycle, takes most of each pair's time.
// Reset (aresetn low, synchronous) returns to the idle phase: the next
// pair starts a new polyline. Held and anchor points need no reset.
// When the receiver stalls, the result holds in the output register and
// the sequencer waits; no result is dropped or repeated.
module lane_centerline_builder #(
    parameter int COORD_BITS = lcb_pkg::CoordBits,
    parameter int ARC_BITS   = lcb_pkg::ArcBits
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lcb_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lcb_pkg::out_item_t m_data
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    lcb_pkg::seq_state_t state_reg, state_next;
    lcb_pkg::phase_t     phase_reg;
    lcb_pkg::in_item_t   in_reg;

    logic signed [COORD_BITS-1:0] c_reg [3];
    logic [COORD_BITS-1:0]        w_reg [2];
    logic signed [COORD_BITS-1:0] hp_reg [3];
    logic [COORD_BITS-1:0]        hw_reg [2];
    logic [ARC_BITS-1:0]          harc_reg;
    logic signed [DW-1:0]         hd_reg [2];
    logic signed [COORD_BITS-1:0] ap_reg [3];
    logic [ARC_BITS-1:0]          aarc_reg;
    logic signed [DW-1:0]         d_reg [3];
    logic                         rev_reg;
    logic [ARC_BITS-1:0]          base_reg;
    logic [PW:0]                  dot_reg;
    logic [1:0]                   dstep_reg;

    logic                 m_valid_reg;
    lcb_pkg::out_item_t   m_data_reg;

    logic                 n_start;
    logic                 n_start_reg;
    logic signed [DW-1:0] n_dx, n_dy, n_dz;
    logic                 n_done;
    logic [DW-1:0]        n_root;

    logic signed [DW-1:0] cand [3];
    logic signed [PW-1:0] dprod;
    logic [ARC_BITS:0]    arc_sum;
    logic [ARC_BITS-1:0]  arc_new;
    logic                 out_free;
    logic                 emit_now;

    lcb_norm #(.DW(DW)) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (n_start),
        .dx      (n_dx),
        .dy      (n_dy),
        .dz      (n_dz),
        .done    (n_done),
        .root    (n_root)
    );

    assign out_free = !m_valid_reg || m_ready;

    // Load the output register in any emit step once it is free
    assign emit_now = out_free && (state_reg == lcb_pkg::ST_EMIT_HELD
                      || state_reg == lcb_pkg::ST_EMIT_FIN
                      || (state_reg == lcb_pkg::ST_UPDATE
                          && phase_reg == lcb_pkg::PH_IDLE));

    // Segment vector: against the anchor after a reversal, else the held point
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cand[i] = DW'(c_reg[i]) - DW'(rev_reg ? ap_reg[i] : hp_reg[i]);
        end
        dprod = (dstep_reg == 2'd0) ? PW'(d_reg[0]) * PW'(hd_reg[0])
                                    : PW'(d_reg[1]) * PW'(hd_reg[1]);
        arc_sum = (ARC_BITS+1)'(base_reg) + (ARC_BITS+1)'(n_root);
        arc_new = arc_sum[ARC_BITS] ? '1 : arc_sum[ARC_BITS-1:0];
    end

    // Drive the norm unit operands for the current step
    always_comb begin
        n_dx = '0;
        n_dy = '0;
        n_dz = '0;
        unique case (state_reg)
            lcb_pkg::ST_LW: begin
                n_dx = DW'(in_reg.left_x) - DW'(c_reg[0]);
                n_dy = DW'(in_reg.left_y) - DW'(c_reg[1]);
                n_dz = DW'(in_reg.left_z) - DW'(c_reg[2]);
            end
            lcb_pkg::ST_RW: begin
                n_dx = DW'(c_reg[0]) - DW'(in_reg.right_x);
                n_dy = DW'(c_reg[1]) - DW'(in_reg.right_y);
                n_dz = DW'(c_reg[2]) - DW'(in_reg.right_z);
            end
            lcb_pkg::ST_SEG: begin
                n_dx = d_reg[0];
                n_dy = d_reg[1];
                n_dz = d_reg[2];
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lcb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lcb_pkg::ST_WAIT;
                end
            end
            lcb_pkg::ST_WAIT: begin
                state_next = lcb_pkg::ST_LW;
            end
            lcb_pkg::ST_LW: begin
                if (n_done) begin
                    state_next = lcb_pkg::ST_RW;
                end
            end
            lcb_pkg::ST_RW: begin
                if (n_done) begin
                    if (phase_reg == lcb_pkg::PH_IDLE) begin
                        state_next = lcb_pkg::ST_UPDATE;
                    end else if (phase_reg == lcb_pkg::PH_ONE) begin
                        state_next = lcb_pkg::ST_SEG;
                    end else begin
                        state_next = lcb_pkg::ST_DOT;
                    end
                end
            end
            lcb_pkg::ST_DOT: begin
                if (dstep_reg == 2'd2) begin
                    state_next = lcb_pkg::ST_DECIDE;
                end
            end
            lcb_pkg::ST_DECIDE: begin
                state_next = lcb_pkg::ST_SEG;
            end
            lcb_pkg::ST_SEG: begin
                if (n_done) begin
                    state_next = (phase_reg == lcb_pkg::PH_HELD && !rev_reg)
                                 ? lcb_pkg::ST_EMIT_HELD : lcb_pkg::ST_UPDATE;
                end
            end
            lcb_pkg::ST_EMIT_HELD: begin
                if (out_free) begin
                    state_next = lcb_pkg::ST_UPDATE;
                end
            end
            lcb_pkg::ST_UPDATE: begin
                if (out_free || phase_reg != lcb_pkg::PH_IDLE) begin
                    state_next = in_reg.final_pair ? lcb_pkg::ST_EMIT_FIN
                                                   : lcb_pkg::ST_IDLE;
                end
            end
            lcb_pkg::ST_EMIT_FIN: begin
                if (out_free) begin
                    state_next = lcb_pkg::ST_IDLE;
                end
            end
            default: state_next = lcb_pkg::ST_IDLE;
        endcase
    end

    // State register; pulse the norm start in the first cycle of each norm step,
    // when that step's operands are already registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lcb_pkg::ST_IDLE;
            n_start_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_start_reg <= (state_next != state_reg)
                           && (state_next == lcb_pkg::ST_LW
                               || state_next == lcb_pkg::ST_RW
                               || state_next == lcb_pkg::ST_SEG);
        end
    end

    assign n_start = n_start_reg;

    // Datapath and phase updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= lcb_pkg::PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                lcb_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_data;
                    end
                end
                lcb_pkg::ST_WAIT: begin
                    c_reg[0] <= COORD_BITS'((DW'(in_reg.left_x)
                                 + DW'(in_reg.right_x)) >>> 1);
                    c_reg[1] <= COORD_BITS'((DW'(in_reg.left_y)
                                 + DW'(in_reg.right_y)) >>> 1);
                    c_reg[2] <= COORD_BITS'((DW'(in_reg.left_z)
                                 + DW'(in_reg.right_z)) >>> 1);
                    rev_reg   <= 1'b0;
                    dstep_reg <= 2'd0;
                    dot_reg   <= '0;
                end
                lcb_pkg::ST_LW: begin
                    if (n_done) begin
                        w_reg[0] <= COORD_BITS'(n_root);
                    end
                end
                lcb_pkg::ST_RW: begin
                    if (n_done) begin
                        w_reg[1] <= COORD_BITS'(n_root);
                        for (int i = 0; i < 3; i++) begin
                            d_reg[i] <= cand[i];
                        end
                        base_reg <= (phase_reg == lcb_pkg::PH_ONE) ? aarc_reg
                                                                   : harc_reg;
                    end
                end
                lcb_pkg::ST_DOT: begin
                    // Accumulate dx*hx + dy*hy, one product a cycle
                    if (dstep_reg != 2'd2) begin
                        dot_reg <= dot_reg + (PW+1)'(dprod);
                    end
                    dstep_reg <= dstep_reg + 2'd1;
                end
                lcb_pkg::ST_DECIDE: begin
                    // Reversed when the sum is at most zero
                    if (dot_reg[PW] || dot_reg == '0) begin
                        rev_reg <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            d_reg[i] <= DW'(c_reg[i]) - DW'(ap_reg[i]);
                        end
                        base_reg <= aarc_reg;
                    end
                end
                lcb_pkg::ST_SEG: begin
                    if (n_done) begin
                        base_reg <= arc_new;
                    end
                end
                lcb_pkg::ST_EMIT_HELD: begin
                    if (out_free) begin
                        m_data_reg  <= '{hp_reg[0], hp_reg[1], hp_reg[2],
                                         hw_reg[0], hw_reg[1], harc_reg, 1'b0};
                        for (int i = 0; i < 3; i++) begin
                            ap_reg[i] <= hp_reg[i];
                        end
                        aarc_reg <= harc_reg;
                    end
                end
                lcb_pkg::ST_UPDATE: begin
                    if (phase_reg == lcb_pkg::PH_IDLE) begin
                        if (out_free) begin
                            m_data_reg  <= '{c_reg[0], c_reg[1], c_reg[2],
                                             w_reg[0], w_reg[1], {ARC_BITS{1'b0}},
                                             1'b0};
                            for (int i = 0; i < 3; i++) begin
                                ap_reg[i] <= c_reg[i];
                                hp_reg[i] <= c_reg[i];
                            end
                            aarc_reg  <= '0;
                            harc_reg  <= '0;
                            hw_reg[0] <= w_reg[0];
                            hw_reg[1] <= w_reg[1];
                            phase_reg <= in_reg.final_pair ? lcb_pkg::PH_IDLE
                                                           : lcb_pkg::PH_ONE;
                        end
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            hp_reg[i] <= c_reg[i];
                        end
                        hd_reg[0] <= d_reg[0];
                        hd_reg[1] <= d_reg[1];
                        hw_reg[0] <= w_reg[0];
                        hw_reg[1] <= w_reg[1];
                        harc_reg  <= base_reg;
                        phase_reg <= in_reg.final_pair ? lcb_pkg::PH_IDLE
                                                       : lcb_pkg::PH_HELD;
                    end
                end
                lcb_pkg::ST_EMIT_FIN: begin
                    if (out_free) begin
                        m_data_reg  <= '{hp_reg[0], hp_reg[1], hp_reg[2],
                                         hw_reg[0], hw_reg[1], harc_reg, 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == lcb_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
